// ----- src/crossing_signal_sequencer_macros.svh -----
// Assertion helpers shared by the sequencer RTL.
// Both expect clk and arst_n in scope.
`ifndef CROSSING_SIGNAL_SEQUENCER_MACROS_SVH
`define CROSSING_SIGNAL_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define CSQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csq: same-cycle check failed");

// Next-cycle implication.
`define CSQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csq: next-cycle check failed");

`endif

// ----- src/csq_pkg.sv -----
`default_nettype none
package csq_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LAMP_PERIOD      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BELL_PERIOD      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TIMEOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LAMP_THRESHOLD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BELL_THRESHOLD   = 3'd5;

	// register reset values
	localparam logic [7:0]  RST_LAMP_PERIOD      = 8'd50;
	localparam logic [7:0]  RST_BELL_PERIOD      = 8'd100;
	localparam logic [15:0] RST_ACTIVE_TIMEOUT   = 16'd3000;
	localparam logic [7:0]  RST_LONG_PRESS_TICKS = 8'd200;
	localparam logic [15:0] RST_LAMP_THRESHOLD   = 16'd0;
	localparam logic [15:0] RST_BELL_THRESHOLD   = 16'd0;

	// reported mode codes
	localparam logic [1:0] MODE_DISABLED = 2'd0;
	localparam logic [1:0] MODE_SHORT    = 2'd1;
	localparam logic [1:0] MODE_LONG     = 2'd2;

	typedef struct packed {
		logic [7:0]  lamp_period;
		logic [7:0]  bell_period;
		logic [15:0] active_timeout;
		logic [7:0]  long_press_ticks;
		logic [15:0] lamp_threshold;
		logic [15:0] bell_threshold;
	} cfg_t;

	typedef struct packed {
		logic press_event;
		logic button_held;
	} in_t;

	typedef struct packed {
		logic       lamp_one;
		logic       lamp_two;
		logic       bell_drive;
		logic [1:0] mode;
	} out_t;

endpackage
`default_nettype wire

// ----- src/csq_cfg_regs.sv -----
`default_nettype none
module csq_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [csq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [csq_pkg::CFG_DATA_W-1:0]   cfg_data,
	output csq_pkg::cfg_t                         cfg
);

	csq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lamp_period      <= csq_pkg::RST_LAMP_PERIOD;
			cfg_q.bell_period      <= csq_pkg::RST_BELL_PERIOD;
			cfg_q.active_timeout   <= csq_pkg::RST_ACTIVE_TIMEOUT;
			cfg_q.long_press_ticks <= csq_pkg::RST_LONG_PRESS_TICKS;
			cfg_q.lamp_threshold   <= csq_pkg::RST_LAMP_THRESHOLD;
			cfg_q.bell_threshold   <= csq_pkg::RST_BELL_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				csq_pkg::CFG_LAMP_PERIOD:      cfg_q.lamp_period      <= cfg_data[7:0];
				csq_pkg::CFG_BELL_PERIOD:      cfg_q.bell_period      <= cfg_data[7:0];
				csq_pkg::CFG_ACTIVE_TIMEOUT:   cfg_q.active_timeout   <= cfg_data;
				csq_pkg::CFG_LONG_PRESS_TICKS: cfg_q.long_press_ticks <= cfg_data[7:0];
				csq_pkg::CFG_LAMP_THRESHOLD:   cfg_q.lamp_threshold   <= cfg_data;
				csq_pkg::CFG_BELL_THRESHOLD:   cfg_q.bell_threshold   <= cfg_data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- src/csq_step.sv -----
`default_nettype none
`include "crossing_signal_sequencer_macros.svh"
module csq_step (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  csq_pkg::in_t        item,
	input  csq_pkg::cfg_t       cfg,
	output csq_pkg::out_t       res
);

	typedef enum logic [2:0] {
		ST_DISABLED = 3'b001,
		ST_SHORT    = 3'b010,
		ST_LONG     = 3'b100
	} state_t;

	state_t      st_q, st_d;
	logic [2:0]  sig_q, sig_d;     // bit0 lamp 1, bit1 lamp 2, bit2 bell
	logic [15:0] act_q, act_d;
	logic [7:0]  lamp_q, lamp_d;
	logic [7:0]  bell_q, bell_d;
	logic [7:0]  hold_q, hold_d;

	always_comb begin
		st_d   = st_q;
		sig_d  = sig_q;
		act_d  = act_q;
		lamp_d = lamp_q;
		bell_d = bell_q;
		hold_d = hold_q;
		case (st_q)
			ST_DISABLED: begin
				sig_d = 3'b000;
				if (item.press_event) begin
					sig_d  = 3'b101;
					lamp_d = cfg.lamp_period;
					bell_d = cfg.bell_period;
					act_d  = cfg.active_timeout;
					hold_d = cfg.long_press_ticks;
					st_d   = ST_SHORT;
				end
			end
			ST_SHORT, ST_LONG: begin
				if (st_q == ST_SHORT) begin
					if (act_q != 16'd0) begin
						if (item.button_held) begin
							if (hold_q == 8'd0)
								st_d = ST_LONG;
							else
								hold_d = hold_q - 8'd1;
						end else begin
							hold_d = cfg.long_press_ticks;
						end
						act_d = act_q - 16'd1;
					end else begin
						st_d = ST_DISABLED;
					end
				end
				if (item.press_event)
					st_d = ST_DISABLED;
				// thresholds compare against the count after this tick's decrement, if any
				if (lamp_q == 8'd0 && act_d > cfg.lamp_threshold) begin
					sig_d[1:0] = ~sig_q[1:0];
					lamp_d     = cfg.lamp_period;
				end else begin
					lamp_d = lamp_q - 8'd1;
				end
				if (bell_q == 8'd0 && act_d > cfg.bell_threshold) begin
					sig_d[2] = 1'b1;
					bell_d   = cfg.bell_period;
				end else begin
					sig_d[2] = 1'b0;
					bell_d   = bell_q - 8'd1;
				end
			end
			default: st_d = ST_DISABLED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_DISABLED;
			sig_q  <= 3'b000;
			act_q  <= 16'd0;
			lamp_q <= 8'd0;
			bell_q <= 8'd0;
			hold_q <= 8'd0;
		end else if (adv) begin
			st_q   <= st_d;
			sig_q  <= sig_d;
			act_q  <= act_d;
			lamp_q <= lamp_d;
			bell_q <= bell_d;
			hold_q <= hold_d;
		end
	end

	always_comb begin
		res.lamp_one   = sig_d[0];
		res.lamp_two   = sig_d[1];
		res.bell_drive = sig_d[2];
		case (st_d)
			ST_SHORT: res.mode = csq_pkg::MODE_SHORT;
			ST_LONG:  res.mode = csq_pkg::MODE_LONG;
			default:  res.mode = csq_pkg::MODE_DISABLED;
		endcase
	end

	// an idle tick with no press drives nothing
	`CSQ_ASSERT_NEXT(a_idle_quiet, adv && st_q == ST_DISABLED && !item.press_event, sig_q == 3'b000)
	// long mode never moves the active count
	`CSQ_ASSERT_NEXT(a_long_frozen, adv && st_q == ST_LONG, act_q == $past(act_q))
	// long mode is only reached through short mode
	`CSQ_ASSERT_NEXT(a_no_skip_long, adv && st_q == ST_DISABLED, st_q != ST_LONG)
	// state only moves on an advancing tick
	`CSQ_ASSERT_NEXT(a_hold_state, !adv, st_q == $past(st_q) && act_q == $past(act_q))

endmodule
`default_nettype wire

// ----- src/crossing_signal_sequencer.sv -----
// Channel | Direction | Payload         | Handshake
// in      | into      | csq_pkg::in_t   | in_valid / in_stall
// out     | out of    | csq_pkg::out_t  | out_valid / out_stall
// cfg     | into      | index + data    | cfg_we, no wait
//
// One tick per clock unless stalled: an input register feeds the state
// update, whose result lands in the output register in the same cycle
// it advances; a result beat follows its input beat through both registers.
// arst_n clears the state to disabled and loads the register defaults.
// out_stall holds the result; the input register still takes one more beat,
// after which in_stall rises until the result is taken.
`default_nettype none
module crossing_signal_sequencer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  csq_pkg::in_t                          in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output csq_pkg::out_t                         out_data,
	input  wire logic                             cfg_we,
	input  wire logic [csq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [csq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	csq_pkg::cfg_t cfg;
	csq_pkg::in_t  in_s1;
	csq_pkg::out_t res;
	csq_pkg::out_t out_q;
	logic          valid_s1;
	logic          out_valid_q;
	logic          adv;
	logic          accept;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			in_s1 <= in_data;
		if (adv)
			out_q <= res;
	end

	csq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	csq_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (in_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
